[hw/rtl/lcdw_pkg.sv]
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types, constants and the microcode table of the character LCD
// 4-bit write sequencer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

	localparam int LINE_COLUMNS = 16;

	localparam int OP_W    = 3;
	localparam int BYTE_W  = 8;
	localparam int NIB_W   = 4;
	localparam int HOLD_W  = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int PULSE_W  = 8;
	localparam int SETTLE_W = 10;
	localparam int BWAIT_W  = 16;
	localparam int LWAIT_W  = 16;
	localparam int PWAIT_W  = 17;

	localparam int STEP_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_COMMAND = 3'd0,
		OP_DATA    = 3'd1,
		OP_CURSOR  = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_INIT    = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_PULSE = 3'd0,
		REG_NIBBLE_SETTLE = 3'd1,
		REG_BYTE_WAIT    = 3'd2,
		REG_LONG_WAIT    = 3'd3,
		REG_POWER_UP     = 3'd4
	} reg_idx_t;

	localparam logic [PULSE_W-1:0]  RST_ENABLE_PULSE  = PULSE_W'(1);
	localparam logic [SETTLE_W-1:0] RST_NIBBLE_SETTLE = SETTLE_W'(50);
	localparam logic [BWAIT_W-1:0]  RST_BYTE_WAIT     = BWAIT_W'(2000);
	localparam logic [LWAIT_W-1:0]  RST_LONG_WAIT     = LWAIT_W'(5000);
	localparam logic [PWAIT_W-1:0]  RST_POWER_UP      = PWAIT_W'(50000);

	localparam logic [BYTE_W-1:0] CURSOR_ROW0 = 8'h80;
	localparam logic [BYTE_W-1:0] CURSOR_ROW1 = 8'hC0;
	localparam logic [BYTE_W-1:0] CMD_CLEAR   = 8'h01;

	typedef struct packed {
		logic [PULSE_W-1:0]  enable_pulse;
		logic [SETTLE_W-1:0] nibble_settle;
		logic [BWAIT_W-1:0]  byte_wait;
		logic [LWAIT_W-1:0]  long_wait;
		logic [PWAIT_W-1:0]  power_up;
	} cfg_t;

	typedef enum logic [1:0] {
		NIB_HI    = 2'd0,
		NIB_LO    = 2'd1,
		NIB_CONST = 2'd2
	} nib_sel_t;

	typedef enum logic [2:0] {
		HOLD_PULSE       = 3'd0,
		HOLD_SETTLE      = 3'd1,
		HOLD_SETTLE_BYTE = 3'd2,
		HOLD_SETTLE_LONG = 3'd3,
		HOLD_SETTLE_BYTE_LONG = 3'd4,
		HOLD_POWER       = 3'd5
	} hold_sel_t;

	typedef enum logic [1:0] {
		SEQ_NEXT     = 2'd0,
		SEQ_BR_CLEAR = 2'd1,
		SEQ_END      = 2'd2
	} seq_t;

	typedef struct packed {
		logic             en;
		nib_sel_t         nib_sel;
		logic [NIB_W-1:0] nib_const;
		hold_sel_t        hold_sel;
		seq_t             seq;
	} ctrl_t;

	localparam logic [STEP_W-1:0] STEP_BYTE       = 5'd0;
	localparam logic [STEP_W-1:0] STEP_INIT       = 5'd4;
	localparam logic [STEP_W-1:0] STEP_CLEAR_TAIL = 5'd29;

	function automatic ctrl_t lcdw_ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		unique case (step)
			// byte routine, nibbles from the latched byte
			5'd0:  w = '{1'b1, NIB_HI, 4'h0, HOLD_PULSE, SEQ_NEXT};
			5'd1:  w = '{1'b0, NIB_HI, 4'h0, HOLD_SETTLE, SEQ_NEXT};
			5'd2:  w = '{1'b1, NIB_LO, 4'h0, HOLD_PULSE, SEQ_BR_CLEAR};
			5'd3:  w = '{1'b0, NIB_LO, 4'h0, HOLD_SETTLE_BYTE, SEQ_END};
			// init program
			5'd4:  w = '{1'b0, NIB_CONST, 4'h0, HOLD_POWER, SEQ_NEXT};
			5'd5:  w = '{1'b1, NIB_CONST, 4'h3, HOLD_PULSE, SEQ_NEXT};
			5'd6:  w = '{1'b0, NIB_CONST, 4'h3, HOLD_SETTLE_LONG, SEQ_NEXT};
			5'd7:  w = '{1'b1, NIB_CONST, 4'h3, HOLD_PULSE, SEQ_NEXT};
			5'd8:  w = '{1'b0, NIB_CONST, 4'h3, HOLD_SETTLE_LONG, SEQ_NEXT};
			5'd9:  w = '{1'b1, NIB_CONST, 4'h3, HOLD_PULSE, SEQ_NEXT};
			5'd10: w = '{1'b0, NIB_CONST, 4'h3, HOLD_SETTLE_LONG, SEQ_NEXT};
			5'd11: w = '{1'b1, NIB_CONST, 4'h2, HOLD_PULSE, SEQ_NEXT};
			5'd12: w = '{1'b0, NIB_CONST, 4'h2, HOLD_SETTLE_LONG, SEQ_NEXT};
			5'd13: w = '{1'b1, NIB_CONST, 4'h2, HOLD_PULSE, SEQ_NEXT};
			5'd14: w = '{1'b0, NIB_CONST, 4'h2, HOLD_SETTLE, SEQ_NEXT};
			5'd15: w = '{1'b1, NIB_CONST, 4'h8, HOLD_PULSE, SEQ_NEXT};
			5'd16: w = '{1'b0, NIB_CONST, 4'h8, HOLD_SETTLE_BYTE, SEQ_NEXT};
			5'd17: w = '{1'b1, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT};
			5'd18: w = '{1'b0, NIB_CONST, 4'h0, HOLD_SETTLE, SEQ_NEXT};
			5'd19: w = '{1'b1, NIB_CONST, 4'hC, HOLD_PULSE, SEQ_NEXT};
			5'd20: w = '{1'b0, NIB_CONST, 4'hC, HOLD_SETTLE_BYTE, SEQ_NEXT};
			5'd21: w = '{1'b1, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT};
			5'd22: w = '{1'b0, NIB_CONST, 4'h0, HOLD_SETTLE, SEQ_NEXT};
			5'd23: w = '{1'b1, NIB_CONST, 4'h1, HOLD_PULSE, SEQ_NEXT};
			5'd24: w = '{1'b0, NIB_CONST, 4'h1, HOLD_SETTLE_BYTE_LONG, SEQ_NEXT};
			5'd25: w = '{1'b1, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_NEXT};
			5'd26: w = '{1'b0, NIB_CONST, 4'h0, HOLD_SETTLE, SEQ_NEXT};
			5'd27: w = '{1'b1, NIB_CONST, 4'h6, HOLD_PULSE, SEQ_NEXT};
			5'd28: w = '{1'b0, NIB_CONST, 4'h6, HOLD_SETTLE_BYTE, SEQ_END};
			// clear tail: low nibble with the long wait added
			5'd29: w = '{1'b0, NIB_LO, 4'h0, HOLD_SETTLE_BYTE_LONG, SEQ_END};
			default: w = '{1'b0, NIB_CONST, 4'h0, HOLD_PULSE, SEQ_END};
		endcase
		return w;
	endfunction

endpackage

[hw/rtl/lcdw_hold_sum.sv]
// ----------------------------------------------------------------------------
// lcdw_hold_sum
// Forms the hold time of one phase from the timing registers.
// ----------------------------------------------------------------------------
module lcdw_hold_sum (
	input  lcdw_pkg::cfg_t                 cfg,
	input  lcdw_pkg::hold_sel_t            hold_sel,
	output logic [lcdw_pkg::HOLD_W-1:0]    hold
);
	import lcdw_pkg::*;

	logic [HOLD_W-1:0] settle;
	logic [HOLD_W-1:0] bwait;
	logic [HOLD_W-1:0] lwait;

	assign settle = HOLD_W'(cfg.nibble_settle);
	assign bwait  = HOLD_W'(cfg.byte_wait);
	assign lwait  = HOLD_W'(cfg.long_wait);

	always_comb begin
		unique case (hold_sel)
			HOLD_PULSE:            hold = HOLD_W'(cfg.enable_pulse);
			HOLD_SETTLE:           hold = settle;
			HOLD_SETTLE_BYTE:      hold = settle + bwait;
			HOLD_SETTLE_LONG:      hold = settle + lwait;
			HOLD_SETTLE_BYTE_LONG: hold = settle + bwait + lwait;
			HOLD_POWER:            hold = HOLD_W'(cfg.power_up);
			default:               hold = '0;
		endcase
	end

endmodule

[hw/rtl/char_lcd_nibble_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns LCD requests into pin phases for a 4-bit character display bus.
// ----------------------------------------------------------------------------
// A request is latched into the step counter and byte register; its phases
// go to the output register one phase per cycle while it is not stalled.
// Byte, cursor and clear run the byte routine, init the init program, and codes 5-7 are dropped.
// The next request is taken in the cycle that issues the final phase.
// Reset: timing registers return to defaults, sequencer idle, output empty.
module char_lcd_nibble_write_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [lcdw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lcdw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lcdw_pkg::OP_W-1:0]          operation,
	input  logic [lcdw_pkg::BYTE_W-1:0]        byte_value,
	input  logic [lcdw_pkg::BYTE_W-1:0]        column,
	input  logic [lcdw_pkg::BYTE_W-1:0]        row,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               reg_select,
	output logic                               enable,
	output logic [lcdw_pkg::NIB_W-1:0]         data_nibble,
	output logic [lcdw_pkg::HOLD_W-1:0]        hold_us,
	output logic                               last
);
	import lcdw_pkg::*;

	cfg_t               cfg_q;
	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic [BYTE_W-1:0]  byte_q;
	logic               rs_q;
	logic               clear_q;

	logic               out_valid_q;
	logic               out_rs_q;
	logic               out_en_q;
	logic [NIB_W-1:0]   out_nib_q;
	logic [HOLD_W-1:0]  out_hold_q;
	logic               out_last_q;

	ctrl_t              ctrl;
	logic               adv;
	logic               done;
	logic               accept;
	logic               op_ok;
	logic [STEP_W-1:0]  step_next;
	logic [STEP_W-1:0]  entry_step;
	logic [BYTE_W-1:0]  entry_byte;
	logic [BYTE_W-1:0]  col_c;
	logic [NIB_W-1:0]   nib;
	logic [HOLD_W-1:0]  hold;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_pulse  <= RST_ENABLE_PULSE;
			cfg_q.nibble_settle <= RST_NIBBLE_SETTLE;
			cfg_q.byte_wait     <= RST_BYTE_WAIT;
			cfg_q.long_wait     <= RST_LONG_WAIT;
			cfg_q.power_up      <= RST_POWER_UP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ENABLE_PULSE:  cfg_q.enable_pulse  <= cfg_data[PULSE_W-1:0];
				REG_NIBBLE_SETTLE: cfg_q.nibble_settle <= cfg_data[SETTLE_W-1:0];
				REG_BYTE_WAIT:     cfg_q.byte_wait     <= cfg_data[BWAIT_W-1:0];
				REG_LONG_WAIT:     cfg_q.long_wait     <= cfg_data[LWAIT_W-1:0];
				REG_POWER_UP:      cfg_q.power_up      <= cfg_data[PWAIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign ctrl   = lcdw_ucode(step_q);
	assign adv    = busy_q && (!out_valid_q || out_ready);
	assign done   = adv && (ctrl.seq == SEQ_END);
	assign in_ready = !busy_q || done;
	assign accept = in_valid && in_ready;
	assign op_ok  = (operation <= OP_W'(OP_INIT));

	always_comb begin
		unique case (ctrl.seq)
			SEQ_BR_CLEAR: step_next = clear_q ? STEP_CLEAR_TAIL : step_q + STEP_W'(1);
			default:      step_next = step_q + STEP_W'(1);
		endcase
	end

	assign col_c = (column < BYTE_W'(LINE_COLUMNS)) ? column : '0;

	always_comb begin
		entry_step = STEP_BYTE;
		entry_byte = byte_value;
		unique case (operation)
			OP_CURSOR: entry_byte = ((row == BYTE_W'(1)) ? CURSOR_ROW1 : CURSOR_ROW0) + col_c;
			OP_CLEAR:  entry_byte = CMD_CLEAR;
			OP_INIT:   entry_step = STEP_INIT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (accept && op_ok) begin
				busy_q <= 1'b1;
				step_q <= entry_step;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				step_q <= step_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q  <= entry_byte;
			rs_q    <= (operation == OP_W'(OP_DATA));
			clear_q <= (operation == OP_W'(OP_CLEAR));
		end
	end

	always_comb begin
		unique case (ctrl.nib_sel)
			NIB_HI:  nib = byte_q[BYTE_W-1:NIB_W];
			NIB_LO:  nib = byte_q[NIB_W-1:0];
			default: nib = ctrl.nib_const;
		endcase
	end

	lcdw_hold_sum u_hold (
		.cfg      (cfg_q),
		.hold_sel (ctrl.hold_sel),
		.hold     (hold)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_rs_q   <= rs_q;
			out_en_q   <= ctrl.en;
			out_nib_q  <= nib;
			out_hold_q <= hold;
			out_last_q <= (ctrl.seq == SEQ_END);
		end
	end

	assign out_valid   = out_valid_q;
	assign reg_select  = out_rs_q;
	assign enable      = out_en_q;
	assign data_nibble = out_nib_q;
	assign hold_us     = out_hold_q;
	assign last        = out_last_q;

endmodule

[hw/rtl/lcdw_checker.sv]
// ----------------------------------------------------------------------------
// lcdw_checker
// Port-level checks of the LCD write sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            reg_select,
	input logic                            enable,
	input logic [lcdw_pkg::NIB_W-1:0]      data_nibble,
	input logic [lcdw_pkg::HOLD_W-1:0]     hold_us,
	input logic                            last
);
	import lcdw_pkg::*;

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reg_select) && $stable(enable)
			&& $stable(data_nibble) && $stable(hold_us) && $stable(last))
		else $error("stalled output beat changed");

	// enable-high phase never closes a request
	a_en_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enable |-> !last)
		else $error("final phase with enable high");

	// a taken non-final beat is followed at once by the next phase
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a request");

	// register select stays constant across one request
	a_rs_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |=> !out_valid || $stable(reg_select))
		else $error("register select changed inside a request");

	// no new request while a mid-request beat is stalled
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last && !out_ready |-> !in_ready)
		else $error("request taken in the middle of a run");

endmodule

bind char_lcd_nibble_write_sequencer lcdw_checker u_lcdw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.reg_select  (reg_select),
	.enable      (enable),
	.data_nibble (data_nibble),
	.hold_us     (hold_us),
	.last        (last)
);
